// ----- rtl/mpfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mpfa_pkg;

   localparam int NUM_POOLS   = 4;
   localparam int MAX_SLOTS   = 256;
   localparam int POOL_W      = $clog2(NUM_POOLS);
   localparam int SLOT_W      = $clog2(MAX_SLOTS);
   localparam int CNT_W       = SLOT_W + 1;
   localparam int ADDR_W      = POOL_W + SLOT_W;
   localparam int STACK_DEPTH = NUM_POOLS * MAX_SLOTS;
   localparam int FAIL_W      = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(MAX_SLOTS);

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_INVALID   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_ACQUIRE  = 2'd0,
      OP_RELEASE  = 2'd1,
      OP_BAD_POOL = 2'd2
   } op_type;

   typedef struct packed {
      logic              kind;
      logic [POOL_W-1:0] pool;
      logic [SLOT_W-1:0] slot_in;
   } req_type;

   typedef struct packed {
      logic              granted;
      logic [SLOT_W-1:0] slot_out;
      status_type        status;
      logic [CNT_W-1:0]  in_use;
      logic [CNT_W-1:0]  high_water;
      logic [FAIL_W-1:0] failure_count;
   } rsp_type;

   typedef struct packed {
      op_type            op;
      logic [POOL_W-1:0] pool;
      logic [SLOT_W-1:0] slot;
   } cmd_type;

endpackage

`default_nettype wire

// ----- rtl/multi_pool_free_list_allocator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Four-pool slot allocator. Each pool hands out slot indices from a free stack
// (acquire, slots come out 0, 1, 2 ... after a refill) and takes them back on
// release; every result for a valid pool carries the pool's in-use count, its
// peak and a shared saturating count of failed acquires. A two-entry request
// queue takes items while the execution side works, so req_full rises only
// when it is full. Each item goes through ST_EXEC, which updates the counters
// and addresses the stack memory, then ST_RESP, which passes the registered
// memory read on once the result register is free; no new item is taken
// before then. No clearing pass is needed after reset or a capacity write: a
// per-pool low mark tells which stack entries still hold their refill value.
// The user must write capacity registers via the csr port only while no item
// is in flight, not enforced by the block; a value over 256 is clamped to 256.

module multi_pool_free_list_allocator_unit (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_push,
   output logic                              req_full,
   input  wire mpfa_pkg::req_type            req_data,
   output logic                              rsp_empty,
   input  wire                               rsp_pop,
   output mpfa_pkg::rsp_type                 rsp_data,
   input  wire                               csr_write_enable,
   input  wire [mpfa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [mpfa_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   mpfa_pkg::cmd_type     cmd;
   logic                  cmd_valid;
   logic                  cmd_take;

   mpfa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take)
   );

   mpfa_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cmd_valid        (cmd_valid),
      .cmd_take         (cmd_take),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data)
   );

   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.granted |-> rsp_data.status == mpfa_pkg::STATUS_OK)
      else $error("granted result without ok status");

   a_grant_in_use: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.granted |-> rsp_data.in_use != '0)
      else $error("granted result with nothing in use");

   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.in_use <= rsp_data.high_water)
      else $error("in-use count above peak");

   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid)
      else $error("execution side took from an empty queue");

endmodule

`default_nettype wire

// ----- rtl/mpfa_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mpfa_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_push,
   output logic                     req_full,
   input  wire mpfa_pkg::req_type   req_data,
   output mpfa_pkg::cmd_type        cmd,
   output logic                     cmd_valid,
   input  wire                      cmd_take
);

   mpfa_pkg::cmd_type                 queue_ff [mpfa_pkg::QUEUE_DEPTH];
   logic [mpfa_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mpfa_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mpfa_pkg::QCNT_W-1:0]       count_ff, count_in;
   mpfa_pkg::cmd_type                 new_cmd;
   logic                              push_xfer;
   logic                              pop_xfer;

   // classify the request before it is queued
   always_comb begin
      new_cmd.pool = req_data.pool;
      new_cmd.slot = req_data.slot_in;
      if (32'(req_data.pool) >= mpfa_pkg::NUM_POOLS) begin
         new_cmd.op = mpfa_pkg::OP_BAD_POOL;
      end else if (req_data.kind) begin
         new_cmd.op = mpfa_pkg::OP_RELEASE;
      end else begin
         new_cmd.op = mpfa_pkg::OP_ACQUIRE;
      end
   end

   assign req_full  = (count_ff == mpfa_pkg::QCNT_W'(mpfa_pkg::QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push_xfer = req_push && !req_full;
   assign pop_xfer  = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = push_xfer ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_xfer ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_xfer && !pop_xfer) begin
         count_in = count_ff + 1'b1;
      end else if (pop_xfer && !push_xfer) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_xfer) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/mpfa_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mpfa_back (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire mpfa_pkg::cmd_type              cmd,
   input  wire                                 cmd_valid,
   output logic                                cmd_take,
   input  wire                                 csr_write_enable,
   input  wire [mpfa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [mpfa_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output logic                                rsp_empty,
   input  wire                                 rsp_pop,
   output mpfa_pkg::rsp_type                   rsp_data
);

   typedef enum logic [1:0] {
      ST_EXEC = 2'b01,
      ST_RESP = 2'b10
   } back_state_type;

   back_state_type                      state_ff, state_in;

   logic [mpfa_pkg::CNT_W-1:0]          cap_ff   [mpfa_pkg::NUM_POOLS];
   logic [mpfa_pkg::CNT_W-1:0]          cap_in   [mpfa_pkg::NUM_POOLS];
   logic [mpfa_pkg::CNT_W-1:0]          count_ff [mpfa_pkg::NUM_POOLS];
   logic [mpfa_pkg::CNT_W-1:0]          count_in [mpfa_pkg::NUM_POOLS];
   logic [mpfa_pkg::CNT_W-1:0]          low_ff   [mpfa_pkg::NUM_POOLS];
   logic [mpfa_pkg::CNT_W-1:0]          low_in   [mpfa_pkg::NUM_POOLS];
   logic [mpfa_pkg::CNT_W-1:0]          peak_ff  [mpfa_pkg::NUM_POOLS];
   logic [mpfa_pkg::CNT_W-1:0]          peak_in  [mpfa_pkg::NUM_POOLS];
   logic [mpfa_pkg::FAIL_W-1:0]         fail_ff, fail_in;

   mpfa_pkg::rsp_type                   pend_ff, pend_in;
   logic                                use_init_ff, use_init_in;
   mpfa_pkg::rsp_type                   out_ff, out_in;
   logic                                out_valid_ff, out_valid_in;

   logic [mpfa_pkg::SLOT_W-1:0]         stack_mem [mpfa_pkg::STACK_DEPTH];
   logic [mpfa_pkg::SLOT_W-1:0]         mem_q_ff;
   logic                                mem_we;
   logic                                mem_re;
   logic [mpfa_pkg::ADDR_W-1:0]         mem_addr;
   logic [mpfa_pkg::SLOT_W-1:0]         mem_wdata;

   logic [mpfa_pkg::CNT_W-1:0]          cur_cap;
   logic [mpfa_pkg::CNT_W-1:0]          cur_count;
   logic [mpfa_pkg::CNT_W-1:0]          cur_low;
   logic [mpfa_pkg::CNT_W-1:0]          cur_peak;
   logic [mpfa_pkg::CNT_W-1:0]          count_dec;
   logic [mpfa_pkg::CNT_W-1:0]          used_after_pop;
   logic [mpfa_pkg::CNT_W-1:0]          init_slot;
   logic [mpfa_pkg::CNT_W-1:0]          cap_clamped;

   assign cur_cap        = cap_ff[cmd.pool];
   assign cur_count      = count_ff[cmd.pool];
   assign cur_low        = low_ff[cmd.pool];
   assign cur_peak       = peak_ff[cmd.pool];
   assign count_dec      = cur_count - 1'b1;
   assign used_after_pop = cur_cap - count_dec;
   // slot that a fresh stack holds at the entry just popped
   assign init_slot      = cur_cap - count_dec - 1'b1;
   assign cap_clamped    = (csr_write_data > mpfa_pkg::CSR_DATA_W'(mpfa_pkg::MAX_SLOTS)) ?
                           mpfa_pkg::CAP_RESET : mpfa_pkg::CNT_W'(csr_write_data);

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      count_in     = count_ff;
      low_in       = low_ff;
      peak_in      = peak_ff;
      fail_in      = fail_ff;
      pend_in      = pend_ff;
      use_init_in  = use_init_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      cmd_take     = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = {cmd.pool, count_dec[mpfa_pkg::SLOT_W-1:0]};
      mem_wdata    = cmd.slot;

      case (state_ff)
         ST_EXEC: begin
            if (cmd_valid) begin
               cmd_take               = 1'b1;
               state_in               = ST_RESP;
               use_init_in            = 1'b0;
               pend_in.granted        = 1'b0;
               pend_in.slot_out       = '0;
               pend_in.status         = mpfa_pkg::STATUS_OK;
               pend_in.in_use         = cur_cap - cur_count;
               pend_in.high_water     = cur_peak;
               pend_in.failure_count  = fail_ff;
               case (cmd.op)
                  mpfa_pkg::OP_ACQUIRE: begin
                     if (cur_count == '0) begin
                        pend_in.status = mpfa_pkg::STATUS_EXHAUSTED;
                        if (fail_ff != '1) begin
                           fail_in = fail_ff + 1'b1;
                        end
                        pend_in.failure_count = fail_in;
                     end else begin
                        // entries below the low mark are untouched since the fill
                        mem_re                = 1'b1;
                        count_in[cmd.pool]    = count_dec;
                        pend_in.granted       = 1'b1;
                        pend_in.slot_out      = init_slot[mpfa_pkg::SLOT_W-1:0];
                        use_init_in           = (count_dec < cur_low);
                        if (count_dec < cur_low) begin
                           low_in[cmd.pool] = count_dec;
                        end
                        pend_in.in_use        = used_after_pop;
                        if (used_after_pop > cur_peak) begin
                           peak_in[cmd.pool]  = used_after_pop;
                           pend_in.high_water = used_after_pop;
                        end
                     end
                  end
                  mpfa_pkg::OP_RELEASE: begin
                     if (mpfa_pkg::CNT_W'(cmd.slot) >= cur_cap || cur_count >= cur_cap) begin
                        pend_in.status = mpfa_pkg::STATUS_INVALID;
                     end else begin
                        mem_we             = 1'b1;
                        mem_addr           = {cmd.pool, cur_count[mpfa_pkg::SLOT_W-1:0]};
                        count_in[cmd.pool] = cur_count + 1'b1;
                        pend_in.in_use     = cur_cap - cur_count - 1'b1;
                     end
                  end
                  default: begin
                     pend_in.status     = mpfa_pkg::STATUS_INVALID;
                     pend_in.in_use     = '0;
                     pend_in.high_water = '0;
                  end
               endcase
            end
         end
         ST_RESP: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_in       = pend_ff;
               if (pend_ff.granted && !use_init_ff) begin
                  out_in.slot_out = mem_q_ff;
               end
               state_in     = ST_EXEC;
            end
         end
         default: begin
            state_in = ST_EXEC;
         end
      endcase

      // capacity write refills the pool; to be issued only while idle, which the block does not enforce
      if (csr_write_enable && 32'(csr_index) < mpfa_pkg::NUM_POOLS) begin
         cap_in[csr_index[mpfa_pkg::POOL_W-1:0]]   = cap_clamped;
         count_in[csr_index[mpfa_pkg::POOL_W-1:0]] = cap_clamped;
         low_in[csr_index[mpfa_pkg::POOL_W-1:0]]   = cap_clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_EXEC;
         out_valid_ff <= 1'b0;
         fail_ff      <= '0;
         for (int i = 0; i < mpfa_pkg::NUM_POOLS; i++) begin
            cap_ff[i]   <= mpfa_pkg::CAP_RESET;
            count_ff[i] <= mpfa_pkg::CAP_RESET;
            low_ff[i]   <= mpfa_pkg::CAP_RESET;
            peak_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         fail_ff      <= fail_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         low_ff       <= low_in;
         peak_ff      <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      use_init_ff <= use_init_in;
      out_ff      <= out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= stack_mem[mem_addr];
      end
   end

endmodule

`default_nettype wire
